// ----- hdl/zlhw_pkg.sv -----
// Package with the types, codes and helper functions of the zip local header walker.
`timescale 1ns / 1ps

package zlhw_pkg;

   localparam int PREVIEW_BYTES = 24;

   localparam logic [31:0] SIG_LOCAL   = 32'h04034b50;
   localparam logic [31:0] SIG_DESC    = 32'h08074b50;
   localparam logic [31:0] SIG_SPAN    = 32'h30304b50;
   localparam logic [31:0] SIG_CENTRAL = 32'h02014b50;
   localparam logic [31:0] SIG_END     = 32'h06054b50;

   localparam logic [4:0]  SIG_LEN  = 5'd4;
   localparam logic [4:0]  HDR_LEN  = 5'd26;
   localparam logic [31:0] DESC_LEN = 32'd12;
   localparam logic [31:0] PREVIEW_LEN = 32'(PREVIEW_BYTES);

   localparam logic [15:0] NAME_LIMIT_RESET = 16'd1023;

   typedef enum logic [2:0] {
      PH_SIG,
      PH_HDR,
      PH_NAME,
      PH_EXTRA,
      PH_PREVIEW,
      PH_DATA,
      PH_DESC
   } phase_type;

   typedef enum logic [2:0] {
      KIND_NAME_BYTE    = 3'd0,
      KIND_HEADER       = 3'd1,
      KIND_PREVIEW_BYTE = 3'd2,
      KIND_END          = 3'd3,
      KIND_BAD_SIG      = 3'd4,
      KIND_NAME_LONG    = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  byte_value;
      logic [31:0] compressed_size;
      logic [31:0] uncompressed_size;
      logic [15:0] name_length;
      logic        encrypted;
      logic [31:0] bad_signature;
   } rsp_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] skip;
   } walk_type;

   function automatic walk_type go_skip(input logic [31:0] count, input phase_type ph);
      walk_type w;
      if (count == 32'd0) begin
         w.phase = PH_SIG;
         w.skip  = 32'd0;
      end else begin
         w.phase = ph;
         w.skip  = count;
      end
      return w;
   endfunction

   function automatic walk_type go_data(input logic [31:0] csize);
      walk_type w;
      if ((PREVIEW_BYTES > 0) && (csize >= PREVIEW_LEN)) begin
         w.phase = PH_PREVIEW;
         w.skip  = PREVIEW_LEN;
      end else begin
         w = go_skip(csize, PH_DATA);
      end
      return w;
   endfunction

   function automatic walk_type go_extra(input logic [15:0] xlen, input logic [31:0] csize);
      walk_type w;
      if (xlen == 16'd0) begin
         w = go_data(csize);
      end else begin
         w.phase = PH_EXTRA;
         w.skip  = {16'd0, xlen};
      end
      return w;
   endfunction

   function automatic walk_type go_name(input logic [15:0] nlen, input logic [15:0] xlen,
                                        input logic [31:0] csize);
      walk_type w;
      if (nlen == 16'd0) begin
         w = go_extra(xlen, csize);
      end else begin
         w.phase = PH_NAME;
         w.skip  = {16'd0, nlen};
      end
      return w;
   endfunction

endpackage

// ----- hdl/zip_local_header_walker.sv -----
// Top level of the zip local header walker: byte parser state and the result register.
//
//   channel  ports                              direction  moves
//   req      req_valid/ready, data, start       in         one archive byte per request
//   rsp      rsp_valid/ready, kind and fields   out        zero or one result per request
//   csr      csr_valid/ready, csr_name_limit    in         name length limit
//
// Each request is parsed in the cycle it is accepted, and its result is in the result
// register in the next cycle; one request per cycle is taken while rsp_ready is high.
// The only stall comes from the result register: a request is taken when the register
// is empty or is being read in the same cycle. Reset puts the parser at the signature
// and the name limit at 1023; csr writes are always taken.
`timescale 1ns / 1ps

module zip_local_header_walker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_archive,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_byte_value,
   output logic [31:0] rsp_compressed_size,
   output logic [31:0] rsp_uncompressed_size,
   output logic [15:0] rsp_name_length,
   output logic        rsp_encrypted,
   output logic [31:0] rsp_bad_signature,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_name_limit
);
   import zlhw_pkg::*;

   logic [15:0] name_limit_ff;
   phase_type   phase_ff, phase_in;
   logic [4:0]  count_ff, count_in;
   logic [31:0] gather_ff, gather_in;
   logic        halted_ff, halted_in;
   logic [31:0] skip_ff, skip_in;
   logic        enc_ff, enc_in;
   logic [31:0] csize_ff, csize_in;
   logic [31:0] usize_ff, usize_in;
   logic [15:0] nlen_ff, nlen_in;
   logic [15:0] xlen_ff, xlen_in;

   logic        req_fire;
   logic        slot_free;
   logic        rsp_load;
   rsp_type     rsp_next;
   rsp_type     rsp_data;

   phase_type   cur_phase;
   logic [4:0]  cur_count;
   logic [31:0] cur_gather;
   logic        cur_halted;
   logic [31:0] skip_dec;
   logic [31:0] shifted;
   walk_type    walk;

   assign csr_ready = 1'b1;
   assign req_ready = slot_free;
   assign req_fire  = req_valid && slot_free;

   // A start flag restarts the parse before this byte is taken.
   assign cur_phase  = req_start_of_archive ? PH_SIG : phase_ff;
   assign cur_count  = req_start_of_archive ? 5'd0 : count_ff;
   assign cur_gather = req_start_of_archive ? 32'd0 : gather_ff;
   assign cur_halted = req_start_of_archive ? 1'b0 : halted_ff;
   assign skip_dec   = skip_ff - 32'd1;
   assign shifted    = {req_data_byte, cur_gather[31:8]};

   always_comb begin
      phase_in  = cur_phase;
      count_in  = cur_count;
      gather_in = cur_gather;
      halted_in = cur_halted;
      skip_in   = skip_ff;
      enc_in    = enc_ff;
      csize_in  = csize_ff;
      usize_in  = usize_ff;
      nlen_in   = nlen_ff;
      xlen_in   = xlen_ff;
      rsp_load  = 1'b0;
      rsp_next  = '0;
      walk      = '0;

      if (!cur_halted) begin
         case (cur_phase)
            PH_SIG: begin
               gather_in = shifted;
               count_in  = cur_count + 5'd1;
               if (count_in >= SIG_LEN) begin
                  count_in  = 5'd0;
                  gather_in = 32'd0;
                  if (shifted == SIG_LOCAL) begin
                     phase_in = PH_HDR;
                     enc_in   = 1'b0;
                     csize_in = 32'd0;
                     usize_in = 32'd0;
                     nlen_in  = 16'd0;
                     xlen_in  = 16'd0;
                  end else if (shifted == SIG_DESC) begin
                     walk     = go_skip(DESC_LEN, PH_DESC);
                     phase_in = walk.phase;
                     skip_in  = walk.skip;
                  end else if (shifted == SIG_SPAN) begin
                     phase_in = PH_SIG;
                  end else if (shifted == SIG_CENTRAL || shifted == SIG_END) begin
                     rsp_load      = 1'b1;
                     rsp_next.kind = KIND_END;
                     halted_in     = 1'b1;
                  end else begin
                     rsp_load               = 1'b1;
                     rsp_next.kind          = KIND_BAD_SIG;
                     rsp_next.bad_signature = shifted;
                     halted_in              = 1'b1;
                  end
               end
            end
            PH_HDR: begin
               case (cur_count)
                  5'd2:  enc_in = req_data_byte[0];
                  5'd14: csize_in[7:0]   = req_data_byte;
                  5'd15: csize_in[15:8]  = req_data_byte;
                  5'd16: csize_in[23:16] = req_data_byte;
                  5'd17: csize_in[31:24] = req_data_byte;
                  5'd18: usize_in[7:0]   = req_data_byte;
                  5'd19: usize_in[15:8]  = req_data_byte;
                  5'd20: usize_in[23:16] = req_data_byte;
                  5'd21: usize_in[31:24] = req_data_byte;
                  5'd22: nlen_in[7:0]    = req_data_byte;
                  5'd23: nlen_in[15:8]   = req_data_byte;
                  5'd24: xlen_in[7:0]    = req_data_byte;
                  5'd25: xlen_in[15:8]   = req_data_byte;
                  default: ;
               endcase
               count_in = cur_count + 5'd1;
               if (count_in >= HDR_LEN) begin
                  count_in             = 5'd0;
                  rsp_load             = 1'b1;
                  rsp_next.name_length = nlen_in;
                  if (nlen_in > name_limit_ff) begin
                     rsp_next.kind = KIND_NAME_LONG;
                     halted_in     = 1'b1;
                  end else begin
                     rsp_next.kind              = KIND_HEADER;
                     rsp_next.compressed_size   = csize_in;
                     rsp_next.uncompressed_size = usize_in;
                     rsp_next.encrypted         = enc_in;
                     walk     = go_name(nlen_in, xlen_in, csize_in);
                     phase_in = walk.phase;
                     skip_in  = walk.skip;
                  end
               end
            end
            PH_NAME: begin
               rsp_load            = 1'b1;
               rsp_next.kind       = KIND_NAME_BYTE;
               rsp_next.byte_value = req_data_byte;
               skip_in             = skip_dec;
               if (skip_dec == 32'd0) begin
                  walk     = go_extra(xlen_ff, csize_ff);
                  phase_in = walk.phase;
                  skip_in  = walk.skip;
               end
            end
            PH_EXTRA: begin
               skip_in = skip_dec;
               if (skip_dec == 32'd0) begin
                  walk     = go_data(csize_ff);
                  phase_in = walk.phase;
                  skip_in  = walk.skip;
               end
            end
            PH_PREVIEW: begin
               rsp_load            = 1'b1;
               rsp_next.kind       = KIND_PREVIEW_BYTE;
               rsp_next.byte_value = req_data_byte;
               skip_in             = skip_dec;
               if (skip_dec == 32'd0) begin
                  walk     = go_skip(csize_ff - PREVIEW_LEN, PH_DATA);
                  phase_in = walk.phase;
                  skip_in  = walk.skip;
               end
            end
            PH_DATA, PH_DESC: begin
               skip_in = skip_dec;
               if (skip_dec == 32'd0) begin
                  phase_in = PH_SIG;
               end
            end
            default: begin
               phase_in  = PH_SIG;
               count_in  = 5'd0;
               gather_in = 32'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_limit_ff <= NAME_LIMIT_RESET;
      end else if (csr_valid) begin
         name_limit_ff <= csr_name_limit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SIG;
         count_ff  <= 5'd0;
         gather_ff <= 32'd0;
         halted_ff <= 1'b0;
         skip_ff   <= 32'd0;
      end else if (req_fire) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         gather_ff <= gather_in;
         halted_ff <= halted_in;
         skip_ff   <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         enc_ff   <= enc_in;
         csize_ff <= csize_in;
         usize_ff <= usize_in;
         nlen_ff  <= nlen_in;
         xlen_ff  <= xlen_in;
      end
   end

   zlhw_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (req_fire && rsp_load),
      .load_data (rsp_next),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind              = rsp_data.kind;
   assign rsp_byte_value        = rsp_data.byte_value;
   assign rsp_compressed_size   = rsp_data.compressed_size;
   assign rsp_uncompressed_size = rsp_data.uncompressed_size;
   assign rsp_name_length       = rsp_data.name_length;
   assign rsp_encrypted         = rsp_data.encrypted;
   assign rsp_bad_signature     = rsp_data.bad_signature;

endmodule

// ----- hdl/zlhw_rsp_reg.sv -----
// Result register that holds one response until the consumer takes it.
`timescale 1ns / 1ps

module zlhw_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  zlhw_pkg::rsp_type load_data,
   output logic             slot_free,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output zlhw_pkg::rsp_type rsp_data
);
   import zlhw_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign slot_free = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule
